### hdl/msu_pkg.sv
package msu_pkg;

    // default sizes of the unit
    localparam int THREAD_COUNT_DEF  = 8;
    localparam int MAILBOX_COUNT_DEF = 8;

    // fixed field widths
    localparam int THREAD_W = 3;
    localparam int MBOX_W   = 3;
    localparam int WORD_W   = 32;

    // number of threads and mailboxes a request can name at all
    localparam int THREAD_LIMIT = 1 << THREAD_W;
    localparam int MBOX_LIMIT   = 1 << MBOX_W;

    // request opcode
    typedef enum logic {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } t_opcode;

    // per-thread wait state
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SEND = 2'd1,
        KIND_RECV = 2'd2
    } t_wait_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CHECK = 2'd1,
        ST_SCAN  = 2'd2,
        ST_POST  = 2'd3
    } t_state;

    // write into the wait table
    typedef struct packed {
        logic                en;
        logic [THREAD_W-1:0] idx;
        t_wait_kind          kind;
        logic [MBOX_W-1:0]   box;
    } t_wt_write;

    // compare of one wait table entry against a wanted kind and mailbox
    typedef struct packed {
        logic [THREAD_W-1:0] idx;
        t_wait_kind          kind;
        logic [MBOX_W-1:0]   box;
    } t_wt_probe;

endpackage

### hdl/msu_wait_table.sv
module msu_wait_table #(
    parameter int THREAD_COUNT = msu_pkg::THREAD_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msu_pkg::t_wt_write i_wr,
    input  msu_pkg::t_wt_probe i_probe,
    output logic               o_hit
);

    // only threads a request can name ever wait
    localparam int DEPTH = (THREAD_COUNT < msu_pkg::THREAD_LIMIT) ? THREAD_COUNT
                                                                  : msu_pkg::THREAD_LIMIT;
    localparam int IDX_W = $clog2(DEPTH);

    msu_pkg::t_wait_kind             r_kind [DEPTH];
    logic [msu_pkg::MBOX_W-1:0]      r_box  [DEPTH];
    logic [IDX_W-1:0]                w_wr_idx;
    logic [IDX_W-1:0]                w_rd_idx;

    assign w_wr_idx = i_wr.idx[IDX_W-1:0];
    assign w_rd_idx = i_probe.idx[IDX_W-1:0];

    // entry storage, one write a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_kind[k] <= msu_pkg::KIND_NONE;
                r_box[k]  <= '0;
            end
        end else if (i_wr.en) begin
            r_kind[w_wr_idx] <= i_wr.kind;
            r_box[w_wr_idx]  <= i_wr.box;
        end
    end

    // shared compare unit, one entry per cycle
    assign o_hit = (r_kind[w_rd_idx] == i_probe.kind) && (r_box[w_rd_idx] == i_probe.box);

endmodule

### hdl/mailbox_sync_unit.sv
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_opcode i_mailbox_id i_caller_thread i_mail_in
// result    out        o_out_valid / i_out_ready  o_op_status o_mail_out o_woke_valid o_woke_thread
//
// a request that blocks or is ignored passes through the check and post states; one that
// completes also passes through the scan state, where the single compare unit walks the wait
// table one thread a cycle from thread 0 upwards over 1 to min(THREAD_COUNT, 8) entries.
// o_in_ready is high only while the sequencer is idle; a result waiting in the output
// register does not hold off the next request, but a finished request waits for it.
// synchronous active-low reset empties all mailboxes and clears the wait table.
module mailbox_sync_unit #(
    parameter int THREAD_COUNT  = msu_pkg::THREAD_COUNT_DEF,
    parameter int MAILBOX_COUNT = msu_pkg::MAILBOX_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [msu_pkg::MBOX_W-1:0]  i_mailbox_id,
    input  logic [msu_pkg::THREAD_W-1:0] i_caller_thread,
    input  logic [msu_pkg::WORD_W-1:0]  i_mail_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_op_status,
    output logic [msu_pkg::WORD_W-1:0]  o_mail_out,
    output logic                        o_woke_valid,
    output logic [msu_pkg::THREAD_W-1:0] o_woke_thread
);

    localparam int WT_DEPTH = (THREAD_COUNT < msu_pkg::THREAD_LIMIT) ? THREAD_COUNT
                                                                     : msu_pkg::THREAD_LIMIT;
    localparam int WT_IDX_W = $clog2(WT_DEPTH);
    localparam int MB_DEPTH = (MAILBOX_COUNT < msu_pkg::MBOX_LIMIT) ? MAILBOX_COUNT
                                                                    : msu_pkg::MBOX_LIMIT;
    localparam int MB_IDX_W = (MB_DEPTH > 1) ? $clog2(MB_DEPTH) : 1;
    localparam int CNT_W    = 7;

    // sequencer and request registers
    msu_pkg::t_state                 r_state, n_state;
    msu_pkg::t_opcode                r_op, n_op;
    logic [msu_pkg::MBOX_W-1:0]      r_box, n_box;
    logic [msu_pkg::THREAD_W-1:0]    r_thr, n_thr;
    logic [msu_pkg::WORD_W-1:0]      r_word, n_word;
    msu_pkg::t_wait_kind             r_target, n_target;
    logic [WT_IDX_W-1:0]             r_scan, n_scan;

    // result being built
    logic                            r_status, n_status;
    logic [msu_pkg::WORD_W-1:0]      r_mail, n_mail;
    logic                            r_woke, n_woke;
    logic [msu_pkg::THREAD_W-1:0]    r_who, n_who;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_status, n_out_status;
    logic [msu_pkg::WORD_W-1:0]      r_out_mail, n_out_mail;
    logic                            r_out_woke, n_out_woke;
    logic [msu_pkg::THREAD_W-1:0]    r_out_who, n_out_who;

    // mailbox slots
    logic [msu_pkg::WORD_W-1:0]      r_slot_word [MB_DEPTH];
    logic                            r_slot_full [MB_DEPTH];
    logic                            w_slot_set;
    logic                            w_slot_clr;
    logic [MB_IDX_W-1:0]             w_box_idx;
    logic                            w_in_range;
    logic                            w_out_free;

    // wait table
    msu_pkg::t_wt_write              w_wt_wr;
    msu_pkg::t_wt_probe              w_wt_probe;
    logic                            w_wt_hit;

    msu_wait_table #(
        .THREAD_COUNT (THREAD_COUNT)
    ) u_wait_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wt_wr),
        .i_probe (w_wt_probe),
        .o_hit   (w_wt_hit)
    );

    assign w_box_idx  = r_box[MB_IDX_W-1:0];
    assign w_in_range = ({(CNT_W - msu_pkg::MBOX_W)'(0), r_box} < CNT_W'(MAILBOX_COUNT))
                     && ({(CNT_W - msu_pkg::THREAD_W)'(0), r_thr} < CNT_W'(THREAD_COUNT));
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_wt_probe.idx  = msu_pkg::THREAD_W'(r_scan);
    assign w_wt_probe.kind = r_target;
    assign w_wt_probe.box  = r_box;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msu_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_box        <= n_box;
        r_thr        <= n_thr;
        r_word       <= n_word;
        r_target     <= n_target;
        r_scan       <= n_scan;
        r_status     <= n_status;
        r_mail       <= n_mail;
        r_woke       <= n_woke;
        r_who        <= n_who;
        r_out_status <= n_out_status;
        r_out_mail   <= n_out_mail;
        r_out_woke   <= n_out_woke;
        r_out_who    <= n_out_who;
    end

    // slot full flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MB_DEPTH; k++) begin
                r_slot_full[k] <= 1'b0;
            end
        end else if (w_slot_set) begin
            r_slot_full[w_box_idx] <= 1'b1;
        end else if (w_slot_clr) begin
            r_slot_full[w_box_idx] <= 1'b0;
        end
    end

    // slot words, written by a completing send
    always_ff @(posedge i_clk) begin
        if (w_slot_set) begin
            r_slot_word[w_box_idx] <= r_word;
        end
    end

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_box        = r_box;
        n_thr        = r_thr;
        n_word       = r_word;
        n_target     = r_target;
        n_scan       = r_scan;
        n_status     = r_status;
        n_mail       = r_mail;
        n_woke       = r_woke;
        n_who        = r_who;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_mail   = r_out_mail;
        n_out_woke   = r_out_woke;
        n_out_who    = r_out_who;
        w_slot_set   = 1'b0;
        w_slot_clr   = 1'b0;
        w_wt_wr      = '{en: 1'b0, idx: r_thr, kind: msu_pkg::KIND_NONE, box: '0};
        o_in_ready   = 1'b0;

        // downstream drains the output register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            msu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = msu_pkg::t_opcode'(i_opcode);
                    n_box    = i_mailbox_id;
                    n_thr    = i_caller_thread;
                    n_word   = i_mail_in;
                    n_status = 1'b0;
                    n_mail   = '0;
                    n_woke   = 1'b0;
                    n_who    = '0;
                    n_scan   = '0;
                    n_state  = msu_pkg::ST_CHECK;
                end
            end

            msu_pkg::ST_CHECK: begin
                n_state = msu_pkg::ST_POST;
                if (w_in_range) begin
                    // caller is running, so its old wait entry goes
                    w_wt_wr.en = 1'b1;
                    if (r_op == msu_pkg::OP_SEND) begin
                        if (r_slot_full[w_box_idx]) begin
                            w_wt_wr.kind = msu_pkg::KIND_SEND;
                            w_wt_wr.box  = r_box;
                            n_status     = 1'b1;
                        end else begin
                            w_slot_set = 1'b1;
                            n_target   = msu_pkg::KIND_RECV;
                            n_state    = msu_pkg::ST_SCAN;
                        end
                    end else begin
                        if (!r_slot_full[w_box_idx]) begin
                            w_wt_wr.kind = msu_pkg::KIND_RECV;
                            w_wt_wr.box  = r_box;
                            n_status     = 1'b1;
                        end else begin
                            w_slot_clr = 1'b1;
                            n_mail     = r_slot_word[w_box_idx];
                            n_target   = msu_pkg::KIND_SEND;
                            n_state    = msu_pkg::ST_SCAN;
                        end
                    end
                end
            end

            msu_pkg::ST_SCAN: begin
                // walk the wait table from thread 0, wake the first match
                if (w_wt_hit) begin
                    w_wt_wr.en  = 1'b1;
                    w_wt_wr.idx = msu_pkg::THREAD_W'(r_scan);
                    n_woke      = 1'b1;
                    n_who       = msu_pkg::THREAD_W'(r_scan);
                    n_state     = msu_pkg::ST_POST;
                end else if (r_scan == WT_IDX_W'(WT_DEPTH - 1)) begin
                    n_state = msu_pkg::ST_POST;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end

            msu_pkg::ST_POST: begin
                // hand the result over once the output register is free
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_mail   = r_mail;
                    n_out_woke   = r_woke;
                    n_out_who    = r_who;
                    n_state      = msu_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = msu_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_op_status   = r_out_status;
    assign o_mail_out    = r_out_mail;
    assign o_woke_valid  = r_out_woke;
    assign o_woke_thread = r_out_who;

endmodule
